/* sv/psrc_pkg.sv */
package psrc_pkg;

	// Fixed widths of the arithmetic
	localparam int ZERO_W     = 32;
	localparam int VEL_W      = 15;
	localparam int FRAC_W     = 9;
	localparam int ACC_W      = 17;
	localparam int MOVE_W     = 8;
	localparam int SQ_W       = 64;
	localparam int PLO_W      = 48;
	localparam int PROD_W     = 80;
	localparam int LIM_W      = 31;
	localparam int SUM_EXTRA  = 17;
	localparam int CFG_IDX_W  = 4;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_DEAD_BAND      = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN_NUMERATOR = 4'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN_DIVISOR   = 4'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_PIXELS     = 4'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_CAL_COUNT      = 4'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_FLIP_X         = 4'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_FLIP_Y         = 4'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_EXCHANGE_AXES  = 4'd7;

	// Register reset values
	localparam logic [14:0] DEAD_BAND_RST      = 15'd64;
	localparam logic [15:0] GAIN_NUMERATOR_RST = 16'd1;
	localparam logic [15:0] GAIN_DIVISOR_RST   = 16'd64;
	localparam logic [6:0]  MAX_PIXELS_RST     = 7'd20;
	localparam logic [15:0] CAL_COUNT_RST      = 16'd64;

	typedef enum logic [1:0] {
		ST_CAL,
		ST_ZERO,
		ST_MOTION,
		ST_RESTART
	} status_t;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_LOAD,
		OP_RESTART,
		OP_ACCUM,
		OP_CDIV,
		OP_CSTORE,
		OP_DELTA,
		OP_MAG,
		OP_SQ,
		OP_PLO,
		OP_PHI,
		OP_LIM,
		OP_CMP,
		OP_MDIV,
		OP_MSTORE,
		OP_ACC,
		OP_EMIT
	} op_t;

	typedef struct packed {
		op_t     op;
		logic    axis;
		status_t code;
	} dp_cmd_t;

	typedef struct packed {
		logic restart;
		logic cal_active;
		logic cal_last;
		logic cal_cnt_zero;
		logic dead;
		logic clamp;
		logic div_busy;
	} dp_sts_t;

endpackage

/* sv/psrc_if.sv */
interface psrc_req_if #(parameter int SAMPLE_BITS = 16);
	logic                          valid;
	logic                          ready;
	logic                          req_type;
	logic signed [SAMPLE_BITS-1:0] field_x;
	logic signed [SAMPLE_BITS-1:0] field_y;

	modport source (output valid, req_type, field_x, field_y, input ready);
	modport sink (input valid, req_type, field_x, field_y, output ready);
endinterface

interface psrc_rsp_if #(parameter int SAMPLE_BITS = 16);
	logic                          valid;
	logic                          ready;
	logic [1:0]                    status;
	logic signed [7:0]             move_x;
	logic signed [7:0]             move_y;
	logic signed [SAMPLE_BITS-1:0] offset_x;
	logic signed [SAMPLE_BITS-1:0] offset_y;

	modport source (output valid, status, move_x, move_y, offset_x, offset_y, input ready);
	modport sink (input valid, status, move_x, move_y, offset_x, offset_y, output ready);
endinterface

interface psrc_cfg_if;
	logic        valid;
	logic        ready;
	logic [3:0]  index;
	logic [15:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* sv/psrc_div.sv */
module psrc_div #(
	parameter int DW = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [DW-1:0]              dividend,
	input  logic [15:0]                divisor,
	input  logic [$clog2(DW+1)-1:0]    nbits,
	output logic                       busy,
	output logic [DW-1:0]              quot
);

	localparam int CW = $clog2(DW+1);
	localparam int TW = DW + 16;

	logic [DW-1:0] rem_q;
	logic [DW-1:0] quot_q;
	logic [15:0]   dsr_q;
	logic [CW-1:0] cnt_q;
	logic [TW-1:0] shifted;
	logic [TW-1:0] rem_ext;
	logic          take;

	// Trial subtract of the divisor aligned to the current quotient bit
	always_comb begin
		shifted = {{(TW-16){1'b0}}, dsr_q} << (cnt_q - CW'(1));
		rem_ext = {16'b0, rem_q};
		take    = rem_ext >= shifted;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= nbits;
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= dividend;
			quot_q <= '0;
			dsr_q  <= divisor;
		end else if (cnt_q != '0) begin
			if (take) begin
				rem_q <= DW'(rem_ext - shifted);
			end
			quot_q <= {quot_q[DW-2:0], take};
		end
	end

	assign busy = cnt_q != '0;
	assign quot = quot_q;

endmodule

/* sv/psrc_dp.sv */
module psrc_dp #(
	parameter int SAMPLE_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [3:0]                    cfg_index,
	input  logic [15:0]                   cfg_data,
	input  logic                          in_req_type,
	input  logic signed [SAMPLE_BITS-1:0] in_field_x,
	input  logic signed [SAMPLE_BITS-1:0] in_field_y,
	input  psrc_pkg::dp_cmd_t             cmd,
	output psrc_pkg::dp_sts_t             sts,
	output logic [1:0]                    out_status,
	output logic signed [7:0]             out_move_x,
	output logic signed [7:0]             out_move_y,
	output logic signed [SAMPLE_BITS-1:0] out_offset_x,
	output logic signed [SAMPLE_BITS-1:0] out_offset_y
);

	localparam int SW = SAMPLE_BITS + psrc_pkg::SUM_EXTRA;
	localparam int DW = (SAMPLE_BITS + 16 > 32) ? SAMPLE_BITS + 16 : 32;
	localparam int CW = $clog2(DW+1);
	localparam int ZW = psrc_pkg::ZERO_W;

	// Configuration
	logic [14:0] db_q;
	logic [15:0] gn_q;
	logic [15:0] gd_q;
	logic [6:0]  mp_q;
	logic [15:0] cc_q;
	logic        fx_q;
	logic        fy_q;
	logic        ex_q;

	// Architectural state
	logic signed [SW-1:0] sum_x_q;
	logic signed [SW-1:0] sum_y_q;
	logic [15:0]          left_q;
	logic signed [ZW-1:0] zero_x_q;
	logic signed [ZW-1:0] zero_y_q;
	logic signed [psrc_pkg::FRAC_W-1:0] frac_x_q;
	logic signed [psrc_pkg::FRAC_W-1:0] frac_y_q;

	// Working registers
	logic                          req_q;
	logic signed [SAMPLE_BITS-1:0] rx_q;
	logic signed [SAMPLE_BITS-1:0] ry_q;
	logic signed [ZW-1:0]          d_x_q;
	logic signed [ZW-1:0]          d_y_q;
	logic [ZW-1:0]                 e_q;
	logic [psrc_pkg::SQ_W-1:0]     sq_q;
	logic [psrc_pkg::PLO_W-1:0]    plo_q;
	logic [psrc_pkg::PROD_W-1:0]   p_q;
	logic [psrc_pkg::LIM_W-1:0]    lim_q;
	logic [psrc_pkg::VEL_W-1:0]    vel_q;
	logic signed [7:0]             mx_q;
	logic signed [7:0]             my_q;

	// Output word
	logic [1:0]                    ost_q;
	logic signed [7:0]             omx_q;
	logic signed [7:0]             omy_q;
	logic signed [SAMPLE_BITS-1:0] ox_q;
	logic signed [SAMPLE_BITS-1:0] oy_q;

	// Combinational
	logic signed [SW-1:0]  sum_sel;
	logic [SW-1:0]         sum_mag;
	logic                  div_start;
	logic [DW-1:0]         div_dividend;
	logic [15:0]           div_divisor;
	logic [CW-1:0]         div_nbits;
	logic                  div_busy;
	logic [DW-1:0]         div_quot;
	logic [DW-1:0]         quot_signed;
	logic signed [ZW-1:0]  dx0;
	logic signed [ZW-1:0]  dy0;
	logic signed [ZW-1:0]  da;
	logic signed [ZW-1:0]  db_sw;
	logic signed [ZW-1:0]  d_sel;
	logic [ZW-1:0]         mag;
	logic [psrc_pkg::VEL_W-1:0] vmax;
	logic signed [psrc_pkg::FRAC_W-1:0] frac_sel;
	logic signed [psrc_pkg::ACC_W-1:0]  vel_s;
	logic signed [psrc_pkg::ACC_W-1:0]  acc;
	logic [psrc_pkg::ACC_W-1:0]         acc_mag;
	logic signed [7:0]                  whole;
	logic signed [psrc_pkg::FRAC_W-1:0] frac_new;

	always_comb begin
		sum_sel  = cmd.axis ? sum_y_q : sum_x_q;
		sum_mag  = sum_sel[SW-1] ? SW'(-sum_sel) : SW'(sum_sel);
		quot_signed = sum_sel[SW-1] ? DW'(-div_quot) : div_quot;

		dx0   = ZW'(rx_q) - zero_x_q;
		dy0   = ZW'(ry_q) - zero_y_q;
		da    = ex_q ? dy0 : dx0;
		db_sw = ex_q ? dx0 : dy0;

		d_sel    = cmd.axis ? d_y_q : d_x_q;
		frac_sel = cmd.axis ? frac_y_q : frac_x_q;
		mag      = d_sel[ZW-1] ? ZW'(-d_sel) : ZW'(d_sel);
		vmax     = {mp_q, 8'b0};

		// Add the signed velocity to the remainder, split whole and fraction
		vel_s    = d_sel[ZW-1] ? -{2'b0, vel_q} : {2'b0, vel_q};
		acc      = psrc_pkg::ACC_W'(frac_sel) + vel_s;
		acc_mag  = acc[psrc_pkg::ACC_W-1] ? psrc_pkg::ACC_W'(-acc) : psrc_pkg::ACC_W'(acc);
		whole    = acc[psrc_pkg::ACC_W-1] ? -$signed(acc_mag[15:8]) : $signed(acc_mag[15:8]);
		frac_new = acc[psrc_pkg::ACC_W-1] ? -$signed({1'b0, acc_mag[7:0]})
		                                 : $signed({1'b0, acc_mag[7:0]});

		div_start    = (cmd.op == psrc_pkg::OP_CDIV) || (cmd.op == psrc_pkg::OP_MDIV);
		div_dividend = (cmd.op == psrc_pkg::OP_CDIV) ? DW'(sum_mag) : DW'(p_q[30:0]);
		div_divisor  = (cmd.op == psrc_pkg::OP_CDIV) ? cc_q : gd_q;
		div_nbits    = (cmd.op == psrc_pkg::OP_CDIV) ? CW'(DW) : CW'(psrc_pkg::VEL_W);

		sts.restart      = req_q;
		sts.cal_active   = left_q != 16'd0;
		sts.cal_last     = left_q == 16'd1;
		sts.cal_cnt_zero = cc_q == 16'd0;
		sts.dead         = mag <= ZW'(db_q);
		sts.clamp        = (p_q[79:64] != 16'd0) || (p_q[63:0] >= 64'(lim_q));
		sts.div_busy     = div_busy;
	end

	psrc_div #(.DW(DW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.nbits    (div_nbits),
		.busy     (div_busy),
		.quot     (div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			db_q     <= psrc_pkg::DEAD_BAND_RST;
			gn_q     <= psrc_pkg::GAIN_NUMERATOR_RST;
			gd_q     <= psrc_pkg::GAIN_DIVISOR_RST;
			mp_q     <= psrc_pkg::MAX_PIXELS_RST;
			cc_q     <= psrc_pkg::CAL_COUNT_RST;
			fx_q     <= 1'b0;
			fy_q     <= 1'b0;
			ex_q     <= 1'b0;
			sum_x_q  <= '0;
			sum_y_q  <= '0;
			left_q   <= psrc_pkg::CAL_COUNT_RST;
			zero_x_q <= '0;
			zero_y_q <= '0;
			frac_x_q <= '0;
			frac_y_q <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					psrc_pkg::CFG_DEAD_BAND:      db_q <= cfg_data[14:0];
					psrc_pkg::CFG_GAIN_NUMERATOR: gn_q <= cfg_data;
					psrc_pkg::CFG_GAIN_DIVISOR:   gd_q <= cfg_data;
					psrc_pkg::CFG_MAX_PIXELS:     mp_q <= cfg_data[6:0];
					psrc_pkg::CFG_CAL_COUNT:      cc_q <= cfg_data;
					psrc_pkg::CFG_FLIP_X:         fx_q <= cfg_data[0];
					psrc_pkg::CFG_FLIP_Y:         fy_q <= cfg_data[0];
					psrc_pkg::CFG_EXCHANGE_AXES:  ex_q <= cfg_data[0];
					default: ;
				endcase
			end
			case (cmd.op)
				psrc_pkg::OP_RESTART: begin
					sum_x_q  <= '0;
					sum_y_q  <= '0;
					frac_x_q <= '0;
					frac_y_q <= '0;
					left_q   <= cc_q;
				end
				psrc_pkg::OP_ACCUM: begin
					sum_x_q <= sum_x_q + SW'(rx_q);
					sum_y_q <= sum_y_q + SW'(ry_q);
					left_q  <= left_q - 16'd1;
				end
				psrc_pkg::OP_CSTORE: begin
					if (cc_q != 16'd0) begin
						if (cmd.axis) zero_y_q <= $signed(quot_signed[ZW-1:0]);
						else          zero_x_q <= $signed(quot_signed[ZW-1:0]);
					end
				end
				psrc_pkg::OP_ACC: begin
					if (cmd.axis) frac_y_q <= frac_new;
					else          frac_x_q <= frac_new;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			psrc_pkg::OP_LOAD: begin
				req_q <= in_req_type;
				rx_q  <= in_field_x;
				ry_q  <= in_field_y;
			end
			psrc_pkg::OP_DELTA: begin
				d_x_q <= fx_q ? -da : da;
				d_y_q <= fy_q ? -db_sw : db_sw;
			end
			psrc_pkg::OP_MAG: begin
				e_q   <= mag - ZW'(db_q);
				vel_q <= '0;
			end
			psrc_pkg::OP_SQ:  sq_q  <= e_q * e_q;
			psrc_pkg::OP_PLO: plo_q <= psrc_pkg::PLO_W'(sq_q[31:0]) * psrc_pkg::PLO_W'(gn_q);
			psrc_pkg::OP_PHI: begin
				p_q <= {psrc_pkg::PLO_W'(sq_q[63:32]) * psrc_pkg::PLO_W'(gn_q), 32'b0}
				       + psrc_pkg::PROD_W'(plo_q);
			end
			psrc_pkg::OP_LIM: lim_q <= (psrc_pkg::LIM_W'(vmax) + psrc_pkg::LIM_W'(1)) * gd_q;
			psrc_pkg::OP_CMP: begin
				if (sts.clamp) vel_q <= vmax;
			end
			psrc_pkg::OP_MSTORE: vel_q <= div_quot[psrc_pkg::VEL_W-1:0];
			psrc_pkg::OP_ACC: begin
				if (cmd.axis) my_q <= whole;
				else          mx_q <= whole;
			end
			psrc_pkg::OP_EMIT: begin
				ost_q <= cmd.code;
				omx_q <= (cmd.code == psrc_pkg::ST_MOTION) ? mx_q : 8'sd0;
				omy_q <= (cmd.code == psrc_pkg::ST_MOTION) ? my_q : 8'sd0;
				ox_q  <= zero_x_q[SAMPLE_BITS-1:0];
				oy_q  <= zero_y_q[SAMPLE_BITS-1:0];
			end
			default: ;
		endcase
	end

	assign out_status   = ost_q;
	assign out_move_x   = omx_q;
	assign out_move_y   = omy_q;
	assign out_offset_x = ox_q;
	assign out_offset_y = oy_q;

endmodule

/* sv/psrc_ctrl.sv */
module psrc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  psrc_pkg::dp_sts_t sts,
	output psrc_pkg::dp_cmd_t cmd
);

	typedef enum logic [3:0] {
		S_IDLE, S_DECODE, S_CDIV, S_CWAIT, S_MAG, S_SQ, S_PLO, S_PHI,
		S_LIM, S_CMP, S_MDIV, S_MWAIT, S_ACC, S_EMIT
	} state_t;

	state_t            state_q;
	logic              axis_q;
	psrc_pkg::status_t code_q;
	logic              in_ready_q;
	logic              out_valid_q;
	logic              emit_ok;

	assign emit_ok = !out_valid_q || out_ready;

	always_comb begin
		cmd.axis = axis_q;
		cmd.code = code_q;
		cmd.op   = psrc_pkg::OP_NONE;
		unique case (state_q)
			S_IDLE:   if (in_valid) cmd.op = psrc_pkg::OP_LOAD;
			S_DECODE: begin
				if (sts.restart)         cmd.op = psrc_pkg::OP_RESTART;
				else if (sts.cal_active) cmd.op = psrc_pkg::OP_ACCUM;
				else                     cmd.op = psrc_pkg::OP_DELTA;
			end
			S_CDIV:  cmd.op = psrc_pkg::OP_CDIV;
			S_CWAIT: if (!sts.div_busy) cmd.op = psrc_pkg::OP_CSTORE;
			S_MAG:   cmd.op = psrc_pkg::OP_MAG;
			S_SQ:    cmd.op = psrc_pkg::OP_SQ;
			S_PLO:   cmd.op = psrc_pkg::OP_PLO;
			S_PHI:   cmd.op = psrc_pkg::OP_PHI;
			S_LIM:   cmd.op = psrc_pkg::OP_LIM;
			S_CMP:   cmd.op = psrc_pkg::OP_CMP;
			S_MDIV:  cmd.op = psrc_pkg::OP_MDIV;
			S_MWAIT: if (!sts.div_busy) cmd.op = psrc_pkg::OP_MSTORE;
			S_ACC:   cmd.op = psrc_pkg::OP_ACC;
			S_EMIT:  if (emit_ok) cmd.op = psrc_pkg::OP_EMIT;
			default: cmd.op = psrc_pkg::OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			axis_q      <= 1'b0;
			code_q      <= psrc_pkg::ST_CAL;
			in_ready_q  <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			// Drop the result word once taken, unless the next one replaces it
			if (out_valid_q && out_ready && state_q != S_EMIT) out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid && in_ready_q) begin
						in_ready_q <= 1'b0;
						state_q    <= S_DECODE;
					end
				end
				S_DECODE: begin
					axis_q <= 1'b0;
					if (sts.restart) begin
						code_q  <= psrc_pkg::ST_RESTART;
						state_q <= S_EMIT;
					end else if (sts.cal_active) begin
						if (sts.cal_last) begin
							code_q  <= psrc_pkg::ST_ZERO;
							state_q <= sts.cal_cnt_zero ? S_EMIT : S_CDIV;
						end else begin
							code_q  <= psrc_pkg::ST_CAL;
							state_q <= S_EMIT;
						end
					end else begin
						code_q  <= psrc_pkg::ST_MOTION;
						state_q <= S_MAG;
					end
				end
				S_CDIV: state_q <= S_CWAIT;
				S_CWAIT: begin
					if (!sts.div_busy) begin
						if (axis_q) begin
							state_q <= S_EMIT;
						end else begin
							axis_q  <= 1'b1;
							state_q <= S_CDIV;
						end
					end
				end
				S_MAG:  state_q <= sts.dead ? S_ACC : S_SQ;
				S_SQ:   state_q <= S_PLO;
				S_PLO:  state_q <= S_PHI;
				S_PHI:  state_q <= S_LIM;
				S_LIM:  state_q <= S_CMP;
				S_CMP:  state_q <= sts.clamp ? S_ACC : S_MDIV;
				S_MDIV: state_q <= S_MWAIT;
				S_MWAIT: if (!sts.div_busy) state_q <= S_ACC;
				S_ACC: begin
					if (axis_q) begin
						state_q <= S_EMIT;
					end else begin
						axis_q  <= 1'b1;
						state_q <= S_MAG;
					end
				end
				S_EMIT: begin
					if (emit_ok) begin
						out_valid_q <= 1'b1;
						in_ready_q  <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready  = in_ready_q;
	assign out_valid = out_valid_q;

endmodule

/* sv/pointing_stick_rate_curve_top.sv */
// Work per word: a restart or plain calibration word goes straight to the result word; the last
//   calibration word runs two DW-step divides (DW = max(32, SAMPLE_BITS+16)) unless the count is zero;
//   a motion word, per axis, stops in the dead band, is clamped, or runs the 15-step divide.
// Throughput: one word at a time; the next word can be accepted in the cycle after the result
//   is registered, and an unread result word holds the next result back.
// Reset (arst_n low): registers to defaults, offsets, sums, fractions zero, count reloaded.
module pointing_stick_rate_curve_top #(
	parameter int SAMPLE_BITS = 16
) (
	input logic           clk,
	input logic           arst_n,
	psrc_req_if.sink      req,
	psrc_rsp_if.source    rsp,
	psrc_cfg_if.sink      cfg
);

	// Control and status between sequencer and datapath
	psrc_pkg::dp_cmd_t cmd;
	psrc_pkg::dp_sts_t sts;

	// Register writes are always taken; the host is to write only while idle, the block does not enforce it
	assign cfg.ready = 1'b1;

	// Sequencer: accept one word, walk the datapath steps, hold the result word
	psrc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Datapath: registers, calibration sums, rate curve, output word
	psrc_dp #(.SAMPLE_BITS(SAMPLE_BITS)) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg.valid),
		.cfg_index    (cfg.index),
		.cfg_data     (cfg.data),
		.in_req_type  (req.req_type),
		.in_field_x   (req.field_x),
		.in_field_y   (req.field_y),
		.cmd          (cmd),
		.sts          (sts),
		.out_status   (rsp.status),
		.out_move_x   (rsp.move_x),
		.out_move_y   (rsp.move_y),
		.out_offset_x (rsp.offset_x),
		.out_offset_y (rsp.offset_y)
	);

	// One word in flight: an accept closes the input until the result is out
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("input accepted while a word is in flight");

	// Motion only on motion results
	a_moves_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && (rsp.status != psrc_pkg::ST_MOTION)) |->
		(rsp.move_x == 8'sd0 && rsp.move_y == 8'sd0))
		else $error("nonzero move on a non-motion result");

	// The divider only runs while a word is being worked
	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		sts.div_busy |-> !req.ready)
		else $error("divider busy while idle");

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

	localparam int SB = 16;
	localparam int CYCLE_LIMIT = 600000;
	localparam int HOLD_CYCLES = 400;

	typedef struct {
		psrc_pkg::status_t  st;
		logic signed [7:0]  mv_x;
		logic signed [7:0]  mv_y;
		logic signed [15:0] off_x;
		logic signed [15:0] off_y;
	} motion_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	psrc_req_if #(.SAMPLE_BITS(SB)) req ();
	psrc_rsp_if #(.SAMPLE_BITS(SB)) rsp ();
	psrc_cfg_if                     cfg ();

	pointing_stick_rate_curve_top #(.SAMPLE_BITS(SB)) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req.sink),
		.rsp    (rsp.source),
		.cfg    (cfg.sink)
	);

	always #5 clk = ~clk;

	// Shadow copy of the register file
	int unsigned dead_band, curve_mul, curve_div, max_pix, cal_cnt;
	bit          flip_x, flip_y, swap_xy;

	// Shadow copy of the tracking state
	int          zero_x, zero_y;
	longint      sum_x, sum_y;
	int unsigned cal_left;
	int          frac_x, frac_y;

	motion_word_t expected_words[$];

	int send_idle = 0;
	int recv_idle = 0;
	bit hold_go   = 1'b0;
	bit stall_rx  = 1'b0;
	int errors    = 0;
	int n_words   = 0;
	int n_results = 0;
	int n_motion  = 0;
	int n_restart = 0;
	int cycles    = 0;

	// Velocity curve for one axis; updates that axis' sub-pixel remainder
	function automatic int curve_axis(input int d, inout int frac);
		longint unsigned mag, v, vmax;
		int acc, whole;
		mag  = (d < 0) ? longint'(-longint'(d)) : longint'(d);
		vmax = longint'(max_pix) * 256;
		if (mag <= dead_band)
			return 0;
		mag -= dead_band;
		v = mag * mag;
		if (curve_div == 0 ||
		    (curve_mul != 0 && v > 64'hFFFF_FFFF_FFFF_FFFF / curve_mul)) begin
			v = vmax;
		end else begin
			v = (v * curve_mul) / curve_div;
			if (v > vmax)
				v = vmax;
		end
		acc   = frac + ((d < 0) ? -int'(v) : int'(v));
		whole = acc / 256;
		frac  = acc - whole * 256;
		return whole;
	endfunction

	// Advance the shadow state by one accepted word and return the word it yields
	function automatic motion_word_t track_word(input logic restart,
			input logic signed [15:0] fx, input logic signed [15:0] fy);
		motion_word_t w;
		int dx, dy, t, mx, my;
		mx = 0;
		my = 0;
		if (restart) begin
			sum_x = 0; sum_y = 0; frac_x = 0; frac_y = 0;
			cal_left = cal_cnt;
			w.st = psrc_pkg::ST_RESTART;
		end else if (cal_left > 0) begin
			sum_x += int'(fx);
			sum_y += int'(fy);
			cal_left--;
			w.st = psrc_pkg::ST_CAL;
			if (cal_left == 0) begin
				// a count of zero written mid-calibration keeps the old zero
				if (cal_cnt != 0) begin
					zero_x = int'(sum_x / longint'(cal_cnt));
					zero_y = int'(sum_y / longint'(cal_cnt));
				end
				w.st = psrc_pkg::ST_ZERO;
			end
		end else begin
			dx = int'(fx) - zero_x;
			dy = int'(fy) - zero_y;
			if (swap_xy) begin
				t = dx; dx = dy; dy = t;
			end
			if (flip_x) dx = -dx;
			if (flip_y) dy = -dy;
			mx = curve_axis(dx, frac_x);
			my = curve_axis(dy, frac_y);
			w.st = psrc_pkg::ST_MOTION;
		end
		w.mv_x  = mx[7:0];
		w.mv_y  = my[7:0];
		w.off_x = zero_x[15:0];
		w.off_y = zero_y[15:0];
		return w;
	endfunction

	// Offer one word; valid stays high so back-to-back words never toggle it
	task automatic send_word(input logic restart, input logic signed [15:0] fx,
			input logic signed [15:0] fy);
		if (send_idle > 0 && $urandom_range(99) < send_idle) begin
			req.valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < send_idle)
				@(posedge clk);
		end
		req.valid    <= 1'b1;
		req.req_type <= restart;
		req.field_x  <= fx;
		req.field_y  <= fy;
		do @(posedge clk); while (!req.ready);
		expected_words.push_back(track_word(restart, fx, fy));
		n_words++;
		if (restart) n_restart++;
	endtask

	task automatic send_sample(input int fx, input int fy);
		send_word(1'b0, fx[15:0], fy[15:0]);
	endtask

	// Drop valid and wait until every expected word is back
	task automatic drain();
		req.valid <= 1'b0;
		cfg.valid <= 1'b0;
		@(posedge clk);
		while (expected_words.size() != 0)
			@(posedge clk);
	endtask

	// Only called while the block is idle; every word yields a result,
	// so an empty expectation queue means nothing is in flight
	task automatic write_reg(input logic [psrc_pkg::CFG_IDX_W-1:0] idx,
			input int unsigned val);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= val[15:0];
		do @(posedge clk); while (!cfg.ready);
		case (idx)
			psrc_pkg::CFG_DEAD_BAND:      dead_band = val & 32'h7FFF;
			psrc_pkg::CFG_GAIN_NUMERATOR: curve_mul = val & 32'hFFFF;
			psrc_pkg::CFG_GAIN_DIVISOR:   curve_div = val & 32'hFFFF;
			psrc_pkg::CFG_MAX_PIXELS:     max_pix   = val & 32'h7F;
			psrc_pkg::CFG_CAL_COUNT:      cal_cnt   = val & 32'hFFFF;
			psrc_pkg::CFG_FLIP_X:         flip_x    = val[0];
			psrc_pkg::CFG_FLIP_Y:         flip_y    = val[0];
			psrc_pkg::CFG_EXCHANGE_AXES:  swap_xy   = val[0];
			default: ;
		endcase
	endtask

	task automatic set_curve(input int unsigned db, input int unsigned gn,
			input int unsigned gd, input int unsigned mp);
		write_reg(psrc_pkg::CFG_DEAD_BAND, db);
		write_reg(psrc_pkg::CFG_GAIN_NUMERATOR, gn);
		write_reg(psrc_pkg::CFG_GAIN_DIVISOR, gd);
		write_reg(psrc_pkg::CFG_MAX_PIXELS, mp);
		cfg.valid <= 1'b0;
	endtask

	task automatic set_axes(input bit fx, input bit fy, input bit sw);
		write_reg(psrc_pkg::CFG_FLIP_X, fx);
		write_reg(psrc_pkg::CFG_FLIP_Y, fy);
		write_reg(psrc_pkg::CFG_EXCHANGE_AXES, sw);
		cfg.valid <= 1'b0;
	endtask

	task automatic set_cal_count(input int unsigned n);
		write_reg(psrc_pkg::CFG_CAL_COUNT, n);
		cfg.valid <= 1'b0;
	endtask

	// Extremes of the fields, the dead band edges, restart, axis options
	task automatic test_directed();
		set_cal_count(3);
		send_word(1'b1, '0, '0);
		send_sample(32767, -32768);
		send_sample(-32768, 32767);
		send_sample(101, -53);
		send_sample(0, 0);
		send_sample(64, -64);
		send_sample(65, -65);
		send_sample(32767, -32768);
		send_sample(-32768, 32767);
		send_sample(-40, 3000);
		drain();
		set_curve(0, 65535, 1, 127);
		set_axes(1, 0, 1);
		send_sample(32767, -32768);
		send_sample(-32768, 1);
		send_sample(1, 0);
		drain();
		// zero divisor: any deflection past the dead band saturates
		set_curve(32767, 0, 0, 0);
		send_sample(32767, -32768);
		drain();
		set_curve(10, 3, 0, 5);
		set_axes(0, 1, 0);
		send_sample(300, -12);
		send_sample(-300, 11);
		drain();
		// count dropped to zero during calibration keeps the old zero
		set_cal_count(2);
		send_word(1'b1, '0, '0);
		send_sample(5000, -5000);
		drain();
		set_cal_count(0);
		send_sample(7000, 7000);
		send_sample(200, 200);
		// restart with a zero count goes straight to motion
		send_word(1'b1, 16'h7FFF, 16'h8000);
		send_sample(-900, 900);
		drain();
	endtask

	// Long calibration count, cut short by a restart with a small count
	task automatic test_long_calibration();
		set_cal_count(65535);
		send_word(1'b1, '0, '0);
		repeat (6) send_sample($urandom, $urandom);
		drain();
		set_cal_count(1);
		send_word(1'b1, '0, '0);
		send_sample(-1, 1);
		drain();
	endtask

	function automatic int unsigned pick(input int unsigned lo_v, input int unsigned hi_v,
			input int unsigned mid_max);
		case ($urandom_range(5))
			0: return lo_v;
			1: return hi_v;
			default: return $urandom_range(mid_max, lo_v);
		endcase
	endfunction

	// Random deflection: mostly near the zero and the dead band, some full range
	function automatic int rand_field(input int centre);
		int r;
		case ($urandom_range(9))
			0, 1:    r = $urandom;
			2:       r = ($urandom_range(1)) ? 32767 : -32768;
			default: r = centre + int'($urandom_range(2 * (dead_band % 2000) + 600))
			             - int'(dead_band % 2000) - 300;
		endcase
		return r;
	endfunction

	task automatic test_random_phase(input int s_idle, input int r_idle, input int words);
		int k;
		send_idle = s_idle;
		recv_idle = r_idle;
		k = 0;
		while (k < words) begin
			set_curve(pick(0, 32767, 400), pick(0, 65535, 64), pick(1, 65535, 256),
			          pick(0, 127, 40));
			set_axes($urandom_range(1), $urandom_range(1), $urandom_range(1));
			set_cal_count(pick(0, 12, 8));
			send_word(1'b1, 16'($urandom), 16'($urandom));
			repeat (40) begin
				if ($urandom_range(24) == 0)
					send_word(1'b1, 16'($urandom), 16'($urandom));
				else
					send_sample(rand_field(zero_x), rand_field(zero_y));
			end
			k += 41;
			drain();
		end
	endtask

	// Receiver holds off while words keep coming, so the block stalls its input
	task automatic test_backpressure();
		send_idle = 0;
		recv_idle = 0;
		hold_go = 1'b1;
		repeat (20) send_sample(rand_field(zero_x), rand_field(zero_y));
		drain();
	endtask

	// Hold ready low for a long stretch on request
	always begin
		wait (hold_go);
		stall_rx = 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		stall_rx = 1'b0;
		hold_go  = 1'b0;
	end

	// Drive ready and check each accepted result against the oldest expectation
	always @(posedge clk) begin
		motion_word_t w;
		rsp.ready <= !stall_rx && (recv_idle == 0 || $urandom_range(99) >= recv_idle);
		if (arst_n && rsp.valid && rsp.ready) begin
			n_results++;
			if (expected_words.size() == 0) begin
				$error("unexpected result word: status %0d", rsp.status);
				errors++;
			end else begin
				w = expected_words.pop_front();
				if (w.st == psrc_pkg::ST_MOTION) n_motion++;
				if (rsp.status !== w.st) begin
					$error("status: expected %0d, got %0d", w.st, rsp.status);
					errors++;
				end
				if (rsp.move_x !== w.mv_x) begin
					$error("move_x: expected %0d, got %0d", w.mv_x, rsp.move_x);
					errors++;
				end
				if (rsp.move_y !== w.mv_y) begin
					$error("move_y: expected %0d, got %0d", w.mv_y, rsp.move_y);
					errors++;
				end
				if (rsp.offset_x !== w.off_x) begin
					$error("offset_x: expected %0d, got %0d", w.off_x, rsp.offset_x);
					errors++;
				end
				if (rsp.offset_y !== w.off_y) begin
					$error("offset_y: expected %0d, got %0d", w.off_y, rsp.offset_y);
					errors++;
				end
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d words pending", cycles,
			         expected_words.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		req.valid    = 1'b0;
		req.req_type = 1'b0;
		req.field_x  = '0;
		req.field_y  = '0;
		cfg.valid    = 1'b0;
		cfg.index    = '0;
		cfg.data     = '0;
		rsp.ready    = 1'b0;
		// shadow state matches the block after reset
		dead_band = 64; curve_mul = 1; curve_div = 64; max_pix = 20; cal_cnt = 64;
		flip_x = 0; flip_y = 0; swap_xy = 0;
		zero_x = 0; zero_y = 0; sum_x = 0; sum_y = 0;
		cal_left = 64; frac_x = 0; frac_y = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset calibration count: 64 samples before motion
		repeat (66) send_sample(rand_field(-120), rand_field(75));
		drain();
		test_directed();
		test_long_calibration();
		test_random_phase(17, 81, 200);
		test_random_phase(81, 17, 200);
		test_random_phase(0, 0, 200);
		test_backpressure();

		repeat (100) @(posedge clk);
		$display("covered %0d words (%0d restarts), %0d results, %0d motion words",
		         n_words, n_restart, n_results, n_motion);
		$display("curve settings swept from zero to full scale, axis options, stalls");
		if (errors == 0 && expected_words.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
